### rtl/date_period_overlap_days_top_macros.svh
// assertion macros shared by the date period overlap blocks
// expects signals named clk and rst in the module that uses them
`ifndef DATE_PERIOD_OVERLAP_DAYS_TOP_MACROS_SVH
`define DATE_PERIOD_OVERLAP_DAYS_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define DPOD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DPOD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dpod_pkg.sv
// shared widths, constants and the month table for the date period overlap block
// no dependencies
`default_nettype none

package dpod_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
  localparam int DNUM_W  = 23;
  localparam int OUT_W   = 22;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // reciprocal of 100, exact for all operands below 2^15
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [6:0]  CENTURY       = 7'd100;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

  localparam logic [8:0] DAYS_BEFORE [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  // stage loads for one day-number lane
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctl_t;

  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    return DAYS_BEFORE[m];
  endfunction

endpackage

`default_nettype wire

### rtl/dpod_req_if.sv
// request channel carrying the two date periods
// depends on dpod_pkg
`default_nettype none

interface dpod_req_if;
  import dpod_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  first_start_year;
  logic [MONTH_W-1:0] first_start_month;
  logic [DAY_W-1:0]   first_start_day;
  logic [YEAR_W-1:0]  first_end_year;
  logic [MONTH_W-1:0] first_end_month;
  logic [DAY_W-1:0]   first_end_day;
  logic [YEAR_W-1:0]  second_start_year;
  logic [MONTH_W-1:0] second_start_month;
  logic [DAY_W-1:0]   second_start_day;
  logic [YEAR_W-1:0]  second_end_year;
  logic [MONTH_W-1:0] second_end_month;
  logic [DAY_W-1:0]   second_end_day;

  modport source (
    output valid, first_start_year, first_start_month, first_start_day,
           first_end_year, first_end_month, first_end_day,
           second_start_year, second_start_month, second_start_day,
           second_end_year, second_end_month, second_end_day,
    input  ready
  );

  modport sink (
    input  valid, first_start_year, first_start_month, first_start_day,
           first_end_year, first_end_month, first_end_day,
           second_start_year, second_start_month, second_start_day,
           second_end_year, second_end_month, second_end_day,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dpod_res_if.sv
// result channel carrying the overlap day count
// depends on dpod_pkg
`default_nettype none

interface dpod_res_if;
  import dpod_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] overlap_days;

  modport source (output valid, overlap_days, input ready);
  modport sink   (input valid, overlap_days, output ready);
endinterface

`default_nettype wire

### rtl/dpod_select.sv
// front stage: orders the four dates and picks the overlap window
// depends on dpod_pkg
`default_nettype none

module dpod_select (
  input  wire logic                          clk,
  input  wire logic                          ld,
  input  wire logic [dpod_pkg::KEY_W-1:0]    s1,
  input  wire logic [dpod_pkg::KEY_W-1:0]    e1,
  input  wire logic [dpod_pkg::KEY_W-1:0]    s2,
  input  wire logic [dpod_pkg::KEY_W-1:0]    e2,
  output logic      [dpod_pkg::KEY_W-1:0]    ks,
  output logic      [dpod_pkg::KEY_W-1:0]    ke,
  output logic                               ok
);
  import dpod_pkg::*;

  logic [KEY_W-1:0] ks_next;
  logic [KEY_W-1:0] ke_next;
  logic             ok_next;

  always_comb begin
    ks_next = (s1 > s2) ? s1 : s2;
    ke_next = (e1 < e2) ? e1 : e2;
    // disjoint periods, or a window that runs backwards
    ok_next = !((e1 < s2) || (s1 > e2)) && (ke_next >= ks_next);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ks <= ks_next;
      ke <= ke_next;
      ok <= ok_next;
    end
  end
endmodule

`default_nettype wire

### rtl/dpod_day_lane.sv
// one lane: date key to proleptic gregorian day number, three stages
// depends on dpod_pkg
`default_nettype none

module dpod_day_lane (
  input  wire logic                          clk,
  input  wire dpod_pkg::lane_ctl_t           ctl,
  input  wire logic [dpod_pkg::KEY_W-1:0]    key,
  output logic      [dpod_pkg::DNUM_W-1:0]   dnum
);
  import dpod_pkg::*;

  localparam int PW = 28;

  logic [YEAR_W-1:0]  y0;
  logic [MONTH_W-1:0] m0;
  logic [DAY_W-1:0]   d0;

  // stage 1
  logic [YEAR_W-1:0]  y1;
  logic [MONTH_W-1:0] m1;
  logic [DAY_W-1:0]   d1;
  logic [DNUM_W-1:0]  y365;
  logic [PW-1:0]      pa;
  logic [PW-1:0]      pb;
  logic [PW-1:0]      pc;

  // stage 2
  logic [7:0]         q100;
  logic [5:0]         q400;
  logic [7:0]         qy;
  logic [14:0]        qy100;
  logic [12:0]        yq4;
  logic               leap;
  logic [DNUM_W-1:0]  base_next;
  logic [8:0]         mo_next;
  logic [DNUM_W-1:0]  base;
  logic [8:0]         mo;

  assign y0 = key[KEY_W-1 -: YEAR_W];
  assign m0 = key[DAY_W +: MONTH_W];
  assign d0 = key[DAY_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      y1   <= y0;
      m1   <= m0;
      d1   <= d0;
      y365 <= DNUM_W'(y0) * DNUM_W'(DAYS_PER_YEAR);
      pa   <= PW'(15'(y0) + 15'd99) * PW'(RECIP_100);
      pb   <= PW'(15'(y0) + 15'd399) * PW'(RECIP_100);
      pc   <= PW'(y0) * PW'(RECIP_100);
    end
  end

  always_comb begin
    q100  = pa[RECIP_SHIFT +: 8];
    q400  = pb[RECIP_SHIFT+2 +: 6];
    qy    = pc[RECIP_SHIFT +: 8];
    qy100 = 15'(qy) * 15'(CENTURY);
    yq4   = 13'((15'(y1) + 15'd3) >> 2);
    // leap: divisible by 4, and not a century unless divisible by 400
    leap  = (y1[1:0] == 2'b00) && ((15'(y1) != qy100) || (qy[1:0] == 2'b00));
    base_next = y365 + DNUM_W'(yq4) - DNUM_W'(q100) + DNUM_W'(q400);
    mo_next   = days_before_month(m1) + 9'(leap && (m1 > FEBRUARY)) + 9'(d1);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      base <= base_next;
      mo   <= mo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      dnum <= base + DNUM_W'(mo);
    end
  end
endmodule

`default_nettype wire

### rtl/dpod_merge.sv
// merge stage: day distance of the two lanes, end-day option and saturation
// depends on dpod_pkg and the assertion macro header
`default_nettype none
`include "date_period_overlap_days_top_macros.svh"

module dpod_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          ld,
  input  wire logic                          ok,
  input  wire logic                          include_end_day,
  input  wire logic [dpod_pkg::DNUM_W-1:0]   ns,
  input  wire logic [dpod_pkg::DNUM_W-1:0]   ne,
  output logic      [dpod_pkg::OUT_W-1:0]    overlap_days
);
  import dpod_pkg::*;

  logic [DNUM_W:0]  cnt;
  logic [OUT_W-1:0] overlap_days_next;

  always_comb begin
    cnt = {1'b0, ne - ns} + (DNUM_W+1)'(include_end_day);
    priority if (!ok || (ne < ns)) begin
      overlap_days_next = '0;
    end else if (cnt > (DNUM_W+1)'(OUT_MAX)) begin
      overlap_days_next = OUT_MAX;
    end else begin
      overlap_days_next = cnt[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      overlap_days <= overlap_days_next;
    end
  end

  `DPOD_ASSERT_NXT(a_disjoint_zero, ld && !ok, overlap_days == '0, "disjoint request gave a count")
endmodule

`default_nettype wire

### rtl/date_period_overlap_days_top.sv
// top level of the date period overlap day counter
// depends on dpod_pkg, dpod_req_if, dpod_res_if, dpod_select, dpod_day_lane, dpod_merge
//
//   channel   dir  handshake         payload
//   req       in   valid / ready     four dates, year/month/day each
//   res       out  valid / ready     overlap_days
//   cfg       in   cfg_wr_en         cfg_wr_data -> include_end_day
//
// one request a cycle while res is ready; a request passes select, three lane
// stages of the day-number conversion with its constant multipliers, and merge
// each stage holds a valid bit and moves whenever the stage after it is free,
// so bubbles collapse and requests keep coming in while a result waits
// rst is synchronous and clears the valid bits and include_end_day
`default_nettype none
`include "date_period_overlap_days_top_macros.svh"

module date_period_overlap_days_top (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  dpod_req_if.sink   req,
  dpod_res_if.source res
);
  import dpod_pkg::*;

  localparam int NSTG = 5;

  // pipeline control
  logic [NSTG-1:0]   vld;
  logic [NSTG-1:0]   vld_next;
  logic [NSTG-1:0]   rdy;
  logic [NSTG-1:0]   ld;
  logic [NSTG-1:0]   src_vld;

  // configuration
  logic              include_end_day;

  // datapath
  logic [KEY_W-1:0]  ks;
  logic [KEY_W-1:0]  ke;
  logic              ok0;
  logic              ok1;
  logic              ok2;
  logic              ok3;
  logic [DNUM_W-1:0] ns;
  logic [DNUM_W-1:0] ne;
  lane_ctl_t         lane_ctl;

  // ready ripples back from the output; a stage is free if empty or draining
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || res.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    src_vld = {vld[NSTG-2:0], req.valid};
    ld      = src_vld & rdy;
    for (int k = 0; k < NSTG; k++) begin
      vld_next[k] = rdy[k] ? src_vld[k] : vld[k];
    end
  end

  assign req.ready = rdy[0];
  assign res.valid = vld[NSTG-1];

  assign lane_ctl.ld1 = ld[1];
  assign lane_ctl.ld2 = ld[2];
  assign lane_ctl.ld3 = ld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld             <= '0;
      include_end_day <= 1'b0;
    end else begin
      vld <= vld_next;
      if (cfg_wr_en) begin
        include_end_day <= cfg_wr_data;
      end
    end
  end

  // overlap flag travels beside the lanes
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ok1 <= ok0;
    end
    if (ld[2]) begin
      ok2 <= ok1;
    end
    if (ld[3]) begin
      ok3 <= ok2;
    end
  end

  // keys order as (year, month, day) when packed year first
  dpod_select u_select (
    .clk (clk),
    .ld  (ld[0]),
    .s1  ({req.first_start_year, req.first_start_month, req.first_start_day}),
    .e1  ({req.first_end_year, req.first_end_month, req.first_end_day}),
    .s2  ({req.second_start_year, req.second_start_month, req.second_start_day}),
    .e2  ({req.second_end_year, req.second_end_month, req.second_end_day}),
    .ks  (ks),
    .ke  (ke),
    .ok  (ok0)
  );

  // lane for the window start
  dpod_day_lane u_lane_start (
    .clk  (clk),
    .ctl  (lane_ctl),
    .key  (ks),
    .dnum (ns)
  );

  // lane for the window end
  dpod_day_lane u_lane_end (
    .clk  (clk),
    .ctl  (lane_ctl),
    .key  (ke),
    .dnum (ne)
  );

  dpod_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .ld              (ld[NSTG-1]),
    .ok              (ok3),
    .include_end_day (include_end_day),
    .ns              (ns),
    .ne              (ne),
    .overlap_days    (res.overlap_days)
  );

  `DPOD_ASSERT_IMP(a_window_order, vld[0] && ok0, ke >= ks, "overlap window runs backwards")
  `DPOD_ASSERT_NXT(a_no_invented, !vld[NSTG-2] && !vld[NSTG-1], !vld[NSTG-1], "result without a request")
endmodule

`default_nettype wire

### tb/tb_date_period_overlap_days_top.sv
// self-checking testbench for the date period overlap day counter
// depends on dpod_pkg, dpod_req_if, dpod_res_if and date_period_overlap_days_top
// directed table first, then random date periods under several idling and config mixes
`default_nettype none

module tb_date_period_overlap_days_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpod_pkg::*;

  // result leaves five stages after acceptance
  localparam int LATENCY      = 5;
  localparam int LIMIT_CYCLES = 200000;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int PRESSURE_AT  = 30;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_YEAR     = 9999;
  localparam int MONTH_FEB    = 2;
  localparam int MONTH_DEC    = 12;
  localparam int KEY_BITS     = YEAR_W + MONTH_W + DAY_W;

  localparam logic [OUT_W-1:0] COUNT_CEIL = '1;

  // days in the year before the first of each month, months above twelve end the year
  localparam int unsigned CUM_DAYS [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };
  localparam int unsigned MONTH_DAYS [13] = '{
    0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  // per random phase: longest sender gap and receiver stall percentage
  localparam int GAP_MAX   [NUM_PHASES] = '{0, 3, 8, 1, 12, 2};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 30, 60, 10, 85, 0};

  // packing year, month, day in this order gives the ordering key directly
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  typedef struct packed {
    cal_date_t a_start;
    cal_date_t a_end;
    cal_date_t b_start;
    cal_date_t b_end;
  } period_pair_t;

  // known marks rows whose count is obvious, the rest go through the predictor
  typedef struct packed {
    period_pair_t     pair;
    logic             known;
    logic [OUT_W-1:0] want_excl;
    logic [OUT_W-1:0] want_incl;
  } dir_row_t;

  localparam int NUM_ROWS = 13;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // one shared leap day in all four dates
    '{'{'{2024, 2, 29}, '{2024, 2, 29}, '{2024, 2, 29}, '{2024, 2, 29}}, 1'b1, 0, 1},
    // every field zero
    '{'{'{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}}, 1'b1, 0, 1},
    // whole valid calendar on both sides
    '{'{'{1, 1, 1}, '{9999, 12, 31}, '{1, 1, 1}, '{9999, 12, 31}}, 1'b1, 3652058, 3652059},
    // widest field values, count clips at the top of the output
    '{'{'{0, 0, 0}, '{16383, 15, 31}, '{0, 0, 0}, '{16383, 15, 31}}, 1'b1,
      COUNT_CEIL, COUNT_CEIL},
    // first period ends the day before the second starts
    '{'{'{1999, 3, 1}, '{2000, 1, 1}, '{2000, 1, 2}, '{2001, 6, 30}}, 1'b1, 0, 0},
    // first period starts the day after the second ends
    '{'{'{2050, 7, 4}, '{2060, 1, 1}, '{2040, 1, 1}, '{2050, 7, 3}}, 1'b1, 0, 0},
    // periods touch on one day
    '{'{'{2010, 1, 1}, '{2010, 5, 5}, '{2010, 5, 5}, '{2010, 12, 31}}, 1'b1, 0, 1},
    // first period runs backwards, overlap end falls before its start
    '{'{'{2020, 6, 1}, '{2020, 1, 1}, '{2020, 1, 1}, '{2020, 12, 31}}, 1'b1, 0, 0},
    // key order and day-number order disagree through a spilled day
    '{'{'{2020, 2, 31}, '{2020, 3, 1}, '{2020, 2, 31}, '{2020, 3, 1}}, 1'b1, 0, 0},
    // across 1900 (no leap day) and 2000 (leap day)
    '{'{'{1899, 12, 1}, '{2001, 1, 31}, '{1900, 2, 1}, '{2000, 3, 31}}, 1'b0, 0, 0},
    // month zero and months past december
    '{'{'{2019, 0, 5}, '{2019, 15, 1}, '{2019, 1, 10}, '{2020, 0, 0}}, 1'b0, 0, 0},
    // day zero and a day past the end of april
    '{'{'{2021, 4, 0}, '{2021, 4, 31}, '{2021, 3, 31}, '{2021, 5, 1}}, 1'b0, 0, 0},
    // year zero counts as a leap year
    '{'{'{0, 1, 1}, '{4, 3, 1}, '{0, 2, 15}, '{1, 1, 1}}, 1'b0, 0, 0}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  dpod_req_if req_ch ();
  dpod_res_if res_ch ();

  date_period_overlap_days_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .res         (res_ch)
  );

  // expected counts in request order, oldest at the front
  logic [OUT_W-1:0] pending_counts [$];

  // our copy of the include-end register
  logic include_end;

  int mismatches;
  int requests_sent;
  int directed_sent;
  int counts_checked;
  int include_writes;
  int cycle_count;

  // receiver controls, written by the stimulus process only
  int stall_pct;
  int hold_trigger;
  int hold_len;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // days since the start of year zero; bad months and days simply run on
  function automatic int unsigned ordinal_day(cal_date_t d);
    int unsigned y;
    int unsigned n;
    y = d.year;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    n += CUM_DAYS[d.month];
    if (d.month > MONTH_FEB && is_leap(y)) n += 1;
    return n + d.day;
  endfunction

  function automatic logic [OUT_W-1:0] overlap_count(period_pair_t p, logic incl);
    logic [KEY_BITS-1:0] s1, e1, s2, e2, ks, ke;
    int unsigned ns, ne, cnt;
    s1  = p.a_start;
    e1  = p.a_end;
    s2  = p.b_start;
    e2  = p.b_end;
    cnt = 0;
    // disjoint periods share nothing
    if (!(e1 < s2 || s1 > e2)) begin
      ks = (s1 > s2) ? s1 : s2;
      ke = (e1 < e2) ? e1 : e2;
      // a backwards overlap, by key or by day number, also gives nothing
      if (ke >= ks) begin
        ns = ordinal_day(ks);
        ne = ordinal_day(ke);
        if (ne >= ns) begin
          cnt = ne - ns + incl;
          if (cnt > COUNT_CEIL) cnt = COUNT_CEIL;
        end
      end
    end
    return OUT_W'(cnt);
  endfunction

  // ---------------------------------------------------------------------------
  // random periods
  // ---------------------------------------------------------------------------

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    if (m == MONTH_FEB && is_leap(y)) return MONTH_DAYS[m] + 1;
    return MONTH_DAYS[m];
  endfunction

  // legal dates fall in the given years, otherwise any bit pattern goes
  function automatic cal_date_t random_date(int unsigned y_lo, int unsigned y_hi, bit legal);
    cal_date_t d;
    if (legal) begin
      d.year  = YEAR_W'($urandom_range(y_hi, y_lo));
      d.month = MONTH_W'($urandom_range(MONTH_DEC, 1));
      d.day   = DAY_W'($urandom_range(month_length(d.year, d.month), 1));
    end else begin
      d.year  = YEAR_W'($urandom);
      d.month = MONTH_W'($urandom);
      d.day   = DAY_W'($urandom);
    end
    return d;
  endfunction

  // mostly well-formed periods drawn from a shared window so they overlap often,
  // some left unordered and some pure noise
  function automatic period_pair_t random_pair();
    period_pair_t p;
    cal_date_t    t;
    int unsigned  pick, lo, hi;
    bit           legal;
    pick  = $urandom_range(99);
    legal = (pick >= 12);
    lo    = $urandom_range(MAX_YEAR, 1);
    case ($urandom_range(3))
      0: hi = lo;
      1: hi = lo + 1;
      2: hi = lo + 40;
      default: begin
        lo = 1;
        hi = MAX_YEAR;
      end
    endcase
    if (hi > MAX_YEAR) hi = MAX_YEAR;
    p.a_start = random_date(lo, hi, legal);
    p.a_end   = random_date(lo, hi, legal);
    p.b_start = random_date(lo, hi, legal);
    p.b_end   = random_date(lo, hi, legal);
    if (pick >= 22) begin
      if (p.a_end < p.a_start) begin
        t         = p.a_start;
        p.a_start = p.a_end;
        p.a_end   = t;
      end
      if (p.b_end < p.b_start) begin
        t         = p.b_start;
        p.b_start = p.b_end;
        p.b_end   = t;
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  task automatic load_payload(period_pair_t p);
    req_ch.first_start_year   <= p.a_start.year;
    req_ch.first_start_month  <= p.a_start.month;
    req_ch.first_start_day    <= p.a_start.day;
    req_ch.first_end_year     <= p.a_end.year;
    req_ch.first_end_month    <= p.a_end.month;
    req_ch.first_end_day      <= p.a_end.day;
    req_ch.second_start_year  <= p.b_start.year;
    req_ch.second_start_month <= p.b_start.month;
    req_ch.second_start_day   <= p.b_start.day;
    req_ch.second_end_year    <= p.b_end.year;
    req_ch.second_end_month   <= p.b_end.month;
    req_ch.second_end_day     <= p.b_end.day;
  endtask

  // holds the request until it is taken, then files its expected count;
  // valid is left high so a following request goes out back to back
  task automatic offer_pair(period_pair_t p, logic known, logic [OUT_W-1:0] count);
    req_ch.valid <= 1'b1;
    load_payload(p);
    do @(posedge clk); while (!req_ch.ready);
    pending_counts.push_back(known ? count : overlap_count(p, include_end));
    requests_sent++;
  endtask

  // stop sending and let every outstanding count come back, plus the pipe depth
  task automatic drain_pipe();
    req_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // only called with the pipe drained
  task automatic write_include(logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    include_end = v;
    include_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_count(logic [OUT_W-1:0] got);
    logic [OUT_W-1:0] want;
    if (pending_counts.size() == 0) begin
      flag_mismatch($sformatf("overlap_days %0d with no request outstanding", got));
    end else begin
      want = pending_counts.pop_front();
      counts_checked++;
      if (got !== want)
        flag_mismatch($sformatf("overlap_days %0d, expected %0d", got, want));
    end
  endtask

  // receiver: random stalls at the rate the phase asks, plus one long hold-off
  // whenever the stimulus bumps hold_trigger
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) check_count(res_ch.overlap_days);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d counts outstanding",
               cycle_count, pending_counts.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    period_pair_t blank;
    dir_row_t     row;
    int           burst_left;
    int           gap_len;

    mismatches     = 0;
    requests_sent  = 0;
    directed_sent  = 0;
    counts_checked = 0;
    include_writes = 0;
    cycle_count    = 0;
    stall_pct      = 0;
    hold_trigger   = 0;
    hold_len       = HOLD_CYCLES;
    include_end    = 1'b0;
    blank          = '0;

    // everything known from time zero while reset is held
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    req_ch.valid <= 1'b0;
    load_payload(blank);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: first with the register at its reset value, then inclusive
    for (int walk = 0; walk < 2; walk++) begin
      if (walk == 1) begin
        drain_pipe();
        write_include(1'b1);
        stall_pct = 25;
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
        row = DIRECTED_ROWS[r];
        offer_pair(row.pair, row.known, include_end ? row.want_incl : row.want_excl);
      end
    end
    directed_sent = requests_sent;

    // random phases, the register flipping between them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe();
      write_include(1'(ph % 2));
      stall_pct  = STALL_PCT[ph];
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while the sender keeps pushing, to back the pipe up
        if (ph == 3 && i == PRESSURE_AT) begin
          hold_trigger++;
          burst_left = 80;
        end
        // sender pauses once mid-phase until every count has come home
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          drain_pipe();
          burst_left = 0;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          gap_len    = $urandom_range(GAP_MAX[ph], 0);
          if (gap_len > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
          end
        end
        offer_pair(random_pair(), 1'b0, '0);
        burst_left--;
      end
    end

    // wind down and watch for stray results
    req_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("covered %0d requests (%0d from the directed table), %0d counts checked",
             requests_sent, directed_sent, counts_checked);
    $display("include_end_day written %0d times, one receiver hold-off of %0d cycles",
             include_writes, hold_len);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
